FILE: hw/rtl/hrae_pkg.sv
`default_nettype none
package hrae_pkg;

	localparam int MAX_POINTS = 256;
	localparam int DIM_BITS   = 16;

	localparam int FUNC_W   = 2;
	localparam int SLOT_W   = 8;
	localparam int VERT_W   = 16;
	localparam int EXTRA_W  = 9;
	localparam int PCOUNT_W = 9;
	localparam int COUNT_W  = 23;

	localparam int ADDR_W = $clog2(MAX_POINTS);
	// slot counters must hold the point count itself
	localparam int IDX_W  = $clog2(MAX_POINTS + 1);
	// width for comparing a slot counter against slot and extra_excluded
	localparam int CMPI_W = (IDX_W > EXTRA_W) ? IDX_W : EXTRA_W;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_EVAL  = 2'd1,
		FUNC_TOTAL = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// total: every apex over the table
	// apex:  candidate as apex
	// end:   candidate as an end point
	typedef enum logic [1:0] {
		PASS_TOTAL,
		PASS_APEX,
		PASS_END
	} pass_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_Q_CHK,
		ST_Q_LAT,
		ST_A_CHK,
		ST_A_LAT,
		ST_B_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic ld_apex;
		logic ld_d_mem;
		logic ld_d_end;
		logic dup_chk;
		logic cmp;
	} ctl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/hrae_if.sv
`default_nettype none
interface hrae_cmd_if;
	import hrae_pkg::*;

	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SLOT_W-1:0]   slot;
	logic [VERT_W-1:0]   vertex;
	logic [EXTRA_W-1:0]  extra_excluded;

	modport source (output valid, func, slot, vertex, extra_excluded, input ready);
	modport sink (input valid, func, slot, vertex, extra_excluded, output ready);
endinterface

interface hrae_rsp_if;
	import hrae_pkg::*;

	logic                valid;
	logic                ready;
	logic [COUNT_W-1:0]  count;
	logic                duplicate;

	modport source (output valid, count, duplicate, input ready);
	modport sink (input valid, count, duplicate, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/hypercube_right_angle_energy.sv
`default_nettype none
// Right-angle triple counter over a table of up to MAX_POINTS hypercube vertices. One command
// transaction is taken at a time and gives exactly one response transaction. A vertex write
// (and the unused func code) goes from idle straight to the done state. A candidate evaluation
// and a total energy run both scan the table through its single read port: at most one stored
// vertex is fetched per cycle and goes through one shared xor-and compare. The response sits
// in an output register, so the next command is taken while it waits. The user must write
// point_count only while idle; the block itself does not enforce it.
module hypercube_right_angle_energy (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [hrae_pkg::PCOUNT_W-1:0]  cfg_wdata,
	hrae_cmd_if.sink                            cmd,
	hrae_rsp_if.source                          rsp
);
	import hrae_pkg::*;

	logic [PCOUNT_W-1:0] point_count_q;
	logic                start;
	logic                busy;
	logic                done;
	logic                out_free;
	ctl_t                ctl;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [DIM_BITS-1:0] rdata;
	logic                ram_we;
	logic [COUNT_W-1:0]  unit_count;
	logic                unit_dup;
	logic                rsp_valid_q;
	logic [COUNT_W-1:0]  rsp_count_q;
	logic                rsp_dup_q;

	assign cmd.ready = !busy;
	assign start     = cmd.valid && !busy;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign ram_we    = start && (cmd.func == FUNC_WRITE) && (cmd.slot < MAX_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	hrae_ram #(
		.WIDTH(DIM_BITS),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(cmd.slot)),
		.wdata (DIM_BITS'(cmd.vertex)),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	hrae_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.func        (cmd.func),
		.slot        (cmd.slot),
		.extra       (cmd.extra_excluded),
		.point_count (point_count_q),
		.out_free    (out_free),
		.ctl         (ctl),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.busy        (busy),
		.done        (done)
	);

	hrae_unit u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cand_in   (cmd.vertex),
		.rdata     (rdata),
		.count     (unit_count),
		.duplicate (unit_dup)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			rsp_count_q <= unit_count;
			rsp_dup_q   <= unit_dup;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.count     = rsp_count_q;
	assign rsp.duplicate = rsp_dup_q;

	// the running count only grows while a command is in progress
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (unit_count >= $past(unit_count)))
		else $error("triple count decreased during a command");

	// writes and unused codes go straight to the done state
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (cmd.func == FUNC_WRITE || cmd.func == FUNC_NONE)) |=> done)
		else $error("short command did not finish in one step");

	// no compare is left in flight once the sequencer is idle
	a_no_stray_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ctl.cmp)
		else $error("pending compare while idle");

	// the table is written only when a command is taken
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (!busy && !rd_en))
		else $error("table write during a scan");
endmodule
`default_nettype wire

FILE: hw/rtl/hrae_ram.sv
`default_nettype none
module hrae_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/hrae_unit.sv
`default_nettype none
module hrae_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire hrae_pkg::ctl_t                 ctl,
	input  wire logic [hrae_pkg::VERT_W-1:0]    cand_in,
	input  wire logic [hrae_pkg::DIM_BITS-1:0]  rdata,
	output      logic [hrae_pkg::COUNT_W-1:0]   count,
	output      logic                           duplicate
);
	import hrae_pkg::*;

	logic [DIM_BITS-1:0] cand_q;
	logic [DIM_BITS-1:0] apex_q;
	logic [DIM_BITS-1:0] d_q;
	logic [COUNT_W-1:0]  count_q;
	logic                dup_q;
	logic                right_angle;

	// shared compare: the streamed end point against the held apex and first arm
	assign right_angle = (((rdata ^ apex_q) & d_q) == '0);

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			cand_q <= DIM_BITS'(cand_in);
			apex_q <= DIM_BITS'(cand_in);
		end else if (ctl.ld_apex) begin
			apex_q <= rdata;
		end
		if (ctl.ld_d_end) begin
			d_q <= cand_q ^ rdata;
		end else if (ctl.ld_d_mem) begin
			d_q <= rdata ^ apex_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dup_q   <= 1'b0;
		end else if (ctl.clear) begin
			count_q <= '0;
			dup_q   <= 1'b0;
		end else begin
			if (ctl.cmp && right_angle && count_q != COUNT_MAX) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (ctl.dup_chk && rdata == cand_q) begin
				dup_q <= 1'b1;
			end
		end
	end

	assign count     = count_q;
	assign duplicate = dup_q;
endmodule
`default_nettype wire

FILE: hw/rtl/hrae_seq.sv
`default_nettype none
module hrae_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [hrae_pkg::FUNC_W-1:0]    func,
	input  wire logic [hrae_pkg::SLOT_W-1:0]    slot,
	input  wire logic [hrae_pkg::EXTRA_W-1:0]   extra,
	input  wire logic [hrae_pkg::PCOUNT_W-1:0]  point_count,
	input  wire logic                           out_free,
	output      hrae_pkg::ctl_t                 ctl,
	output      logic                           rd_en,
	output      logic [hrae_pkg::ADDR_W-1:0]    rd_addr,
	output      logic                           busy,
	output      logic                           done
);
	import hrae_pkg::*;

	state_t              state_q, state_d;
	pass_t               pass_q;
	logic [IDX_W-1:0]    n_q;
	logic [CMPI_W-1:0]   pos_q;
	logic [CMPI_W-1:0]   extra_q;
	logic [IDX_W-1:0]    q_q, a_q, b_q;
	logic                pend_s1;
	logic                q_end, a_end, b_end;
	logic                q_skip, a_skip, b_skip;

	assign q_end = (q_q >= n_q);
	assign a_end = (a_q >= n_q);
	assign b_end = (b_q >= n_q);

	assign q_skip = (pass_q == PASS_END) && (CMPI_W'(q_q) == pos_q);
	assign a_skip = (pass_q == PASS_TOTAL) ? (a_q == q_q) : (CMPI_W'(a_q) == pos_q);
	assign b_skip = (pass_q == PASS_TOTAL) ? (b_q == q_q) :
		((CMPI_W'(b_q) == pos_q) || (pass_q == PASS_END && b_q == q_q));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (func == FUNC_EVAL) begin
						state_d = ST_A_CHK;
					end else if (func == FUNC_TOTAL) begin
						state_d = ST_Q_CHK;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_Q_CHK: begin
				if (q_end) begin
					state_d = ST_DONE;
				end else if (!q_skip) begin
					state_d = ST_Q_LAT;
				end
			end
			ST_Q_LAT: begin
				state_d = (pass_q == PASS_END) ? ST_B_RUN : ST_A_CHK;
			end
			ST_A_CHK: begin
				if (a_end) begin
					state_d = ST_Q_CHK;
				end else if (!a_skip) begin
					state_d = ST_A_LAT;
				end
			end
			ST_A_LAT: begin
				state_d = ST_B_RUN;
			end
			ST_B_RUN: begin
				if (b_end) begin
					state_d = (pass_q == PASS_END) ? ST_Q_CHK : ST_A_CHK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl         = '0;
		ctl.clear   = (state_q == ST_IDLE) && start;
		ctl.ld_apex = (state_q == ST_Q_LAT);
		ctl.ld_d_end = (state_q == ST_Q_LAT) && (pass_q == PASS_END);
		ctl.ld_d_mem = (state_q == ST_A_LAT);
		ctl.dup_chk = (state_q == ST_A_LAT) && (pass_q == PASS_APEX) &&
			(CMPI_W'(a_q) != extra_q);
		ctl.cmp     = pend_s1;
		rd_en       = 1'b0;
		rd_addr     = '0;
		unique case (state_q)
			ST_Q_CHK: begin
				rd_en   = !q_end && !q_skip;
				rd_addr = q_q[ADDR_W-1:0];
			end
			ST_A_CHK: begin
				rd_en   = !a_end && !a_skip;
				rd_addr = a_q[ADDR_W-1:0];
			end
			ST_B_RUN: begin
				rd_en   = !b_end;
				rd_addr = b_q[ADDR_W-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= PASS_TOTAL;
			n_q     <= '0;
			pos_q   <= '0;
			extra_q <= '0;
			q_q     <= '0;
			a_q     <= '0;
			b_q     <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			// end point read this cycle is compared when its data returns
			pend_s1 <= (state_q == ST_B_RUN) && !b_end && !b_skip;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						pass_q  <= (func == FUNC_TOTAL) ? PASS_TOTAL : PASS_APEX;
						n_q     <= (point_count > MAX_POINTS) ? IDX_W'(MAX_POINTS)
							: IDX_W'(point_count);
						pos_q   <= CMPI_W'(slot);
						extra_q <= CMPI_W'(extra);
						q_q     <= '0;
						a_q     <= '0;
					end
				end
				ST_Q_CHK: begin
					if (!q_end && q_skip) begin
						q_q <= q_q + IDX_W'(1);
					end
				end
				ST_Q_LAT: begin
					if (pass_q == PASS_END) begin
						b_q <= '0;
					end else begin
						a_q <= '0;
					end
				end
				ST_A_CHK: begin
					if (a_end) begin
						if (pass_q == PASS_APEX) begin
							pass_q <= PASS_END;
							q_q    <= '0;
						end else begin
							q_q <= q_q + IDX_W'(1);
						end
					end else if (a_skip) begin
						a_q <= a_q + IDX_W'(1);
					end
				end
				ST_A_LAT: begin
					b_q <= a_q + IDX_W'(1);
				end
				ST_B_RUN: begin
					if (!b_end) begin
						b_q <= b_q + IDX_W'(1);
					end else if (pass_q == PASS_END) begin
						q_q <= q_q + IDX_W'(1);
					end else begin
						a_q <= a_q + IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire
